[src/line_intersection_assert.svh]
// Assertion macros for the line intersection block.
// No dependencies; included by line_intersection, which carries the checks.
`ifndef LINE_INTERSECTION_ASSERT_SVH
`define LINE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LNX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LNX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lnx_pkg.sv]
// Shared widths, beat types and the divider tag for the line intersection block.
// No dependencies; the front end, the divider cell and the top module use it by scoped names.
`timescale 1ns / 1ps

package lnx_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int OUT_WIDTH   = 24;
  localparam int FRAC_BITS   = 4;

  // exact intermediate widths
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * COORD_WIDTH + 1;
  localparam int CROSS_W = 2 * COORD_WIDTH;
  localparam int NUM_W   = 2 * COORD_WIDTH + 2;
  localparam int DEN_W   = 2 * COORD_WIDTH + 1;
  localparam int MX_W    = 3 * COORD_WIDTH + 1;
  localparam int MN_W    = 3 * COORD_WIDTH + 2;
  localparam int NX_W    = 3 * COORD_WIDTH + 3;
  // quotient bits: one more than the output so saturation is visible
  localparam int Q_W     = OUT_WIDTH + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_dx;
    logic signed [COORD_WIDTH-1:0] a_dy;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_dx;
    logic signed [COORD_WIDTH-1:0] b_dy;
  } lnx_in_t;

  typedef struct packed {
    logic                        hit;
    logic signed [OUT_WIDTH-1:0] cross_x;
    logic signed [OUT_WIDTH-1:0] cross_y;
    logic                        clipped;
  } lnx_out_t;

  // numerators and denominator leaving the product front end
  typedef struct packed {
    logic signed [NX_W-1:0]  nx;
    logic signed [NX_W-1:0]  ny;
    logic signed [DEN_W-1:0] den;
  } lnx_prod_t;

  // side information riding along the divider chain
  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } lnx_tag_t;

endpackage

[src/lnx_front.sv]
// Product front end: cross products, num/den, and the exact crossing numerators.
// Depends on lnx_pkg.
`timescale 1ns / 1ps

module lnx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lnx_pkg::lnx_in_t   in_data,
  output logic               out_valid,
  output lnx_pkg::lnx_prod_t out_data
);

  localparam int CW = lnx_pkg::COORD_WIDTH;

  // stage 1: point differences and the four cross products
  logic signed [lnx_pkg::DIFF_W-1:0]  dy_w, dx_w;
  logic signed [lnx_pkg::PROD_W-1:0]  s1_p1_r, s1_p2_r;
  logic signed [lnx_pkg::CROSS_W-1:0] s1_p3_r, s1_p4_r;
  logic signed [CW-1:0]               s1_bx_r, s1_by_r, s1_bdx_r, s1_bdy_r;
  logic                               s1_valid_r;

  // stage 2: num and den
  logic signed [lnx_pkg::NUM_W-1:0]   s2_num_r;
  logic signed [lnx_pkg::DEN_W-1:0]   s2_den_r;
  logic signed [CW-1:0]               s2_bx_r, s2_by_r, s2_bdx_r, s2_bdy_r;
  logic                               s2_valid_r;

  // stage 3: scaled point and direction terms
  logic signed [lnx_pkg::MX_W-1:0]    s3_mx1_r, s3_my1_r;
  logic signed [lnx_pkg::MN_W-1:0]    s3_mx2_r, s3_my2_r;
  logic signed [lnx_pkg::DEN_W-1:0]   s3_den_r;
  logic                               s3_valid_r;

  // stage 4: numerators
  lnx_pkg::lnx_prod_t                 s4_data_r;
  logic                               s4_valid_r;

  assign dy_w = lnx_pkg::DIFF_W'(in_data.b_y) - lnx_pkg::DIFF_W'(in_data.a_y);
  assign dx_w = lnx_pkg::DIFF_W'(in_data.b_x) - lnx_pkg::DIFF_W'(in_data.a_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_p1_r  <= lnx_pkg::PROD_W'(in_data.a_dx) * lnx_pkg::PROD_W'(dy_w);
    s1_p2_r  <= lnx_pkg::PROD_W'(in_data.a_dy) * lnx_pkg::PROD_W'(dx_w);
    s1_p3_r  <= lnx_pkg::CROSS_W'(in_data.a_dy) * lnx_pkg::CROSS_W'(in_data.b_dx);
    s1_p4_r  <= lnx_pkg::CROSS_W'(in_data.b_dy) * lnx_pkg::CROSS_W'(in_data.a_dx);
    s1_bx_r  <= in_data.b_x;
    s1_by_r  <= in_data.b_y;
    s1_bdx_r <= in_data.b_dx;
    s1_bdy_r <= in_data.b_dy;

    s2_num_r <= lnx_pkg::NUM_W'(s1_p1_r) - lnx_pkg::NUM_W'(s1_p2_r);
    s2_den_r <= lnx_pkg::DEN_W'(s1_p3_r) - lnx_pkg::DEN_W'(s1_p4_r);
    s2_bx_r  <= s1_bx_r;
    s2_by_r  <= s1_by_r;
    s2_bdx_r <= s1_bdx_r;
    s2_bdy_r <= s1_bdy_r;

    s3_mx1_r <= lnx_pkg::MX_W'(s2_bx_r) * lnx_pkg::MX_W'(s2_den_r);
    s3_my1_r <= lnx_pkg::MX_W'(s2_by_r) * lnx_pkg::MX_W'(s2_den_r);
    s3_mx2_r <= lnx_pkg::MN_W'(s2_bdx_r) * lnx_pkg::MN_W'(s2_num_r);
    s3_my2_r <= lnx_pkg::MN_W'(s2_bdy_r) * lnx_pkg::MN_W'(s2_num_r);
    s3_den_r <= s2_den_r;

    s4_data_r.nx  <= lnx_pkg::NX_W'(s3_mx1_r) + lnx_pkg::NX_W'(s3_mx2_r);
    s4_data_r.ny  <= lnx_pkg::NX_W'(s3_my1_r) + lnx_pkg::NX_W'(s3_my2_r);
    s4_data_r.den <= s3_den_r;
  end

  assign out_valid = s4_valid_r;
  assign out_data  = s4_data_r;

endmodule

[src/lnx_div_cell.sv]
// One restoring-division cell: settles one quotient bit for both coordinates.
// Depends on lnx_pkg.
`timescale 1ns / 1ps

module lnx_div_cell #(
  parameter int RW      = 62,
  parameter int DD_W    = 37,
  parameter int BIT_POS = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  lnx_pkg::lnx_tag_t         in_tag,
  input  logic [DD_W-1:0]           in_dd,
  input  logic [RW-1:0]             in_rem_x,
  input  logic [RW-1:0]             in_rem_y,
  input  logic [lnx_pkg::Q_W-1:0]   in_q_x,
  input  logic [lnx_pkg::Q_W-1:0]   in_q_y,
  output logic                      out_valid,
  output lnx_pkg::lnx_tag_t         out_tag,
  output logic [DD_W-1:0]           out_dd,
  output logic [RW-1:0]             out_rem_x,
  output logic [RW-1:0]             out_rem_y,
  output logic [lnx_pkg::Q_W-1:0]   out_q_x,
  output logic [lnx_pkg::Q_W-1:0]   out_q_y
);

  logic [RW-1:0]           dd_sh;
  logic [RW:0]             sub_x, sub_y;
  logic [RW-1:0]           rem_x_nxt, rem_y_nxt;
  logic [lnx_pkg::Q_W-1:0] q_x_nxt, q_y_nxt;
  logic                    valid_r;
  lnx_pkg::lnx_tag_t       tag_r;
  logic [DD_W-1:0]         dd_r;
  logic [RW-1:0]           rem_x_r, rem_y_r;
  logic [lnx_pkg::Q_W-1:0] q_x_r, q_y_r;

  assign dd_sh = RW'(in_dd) << BIT_POS;
  assign sub_x = {1'b0, in_rem_x} - {1'b0, dd_sh};
  assign sub_y = {1'b0, in_rem_y} - {1'b0, dd_sh};

  // no borrow means the shifted divisor fits: take it and set the bit
  always_comb begin
    rem_x_nxt        = sub_x[RW] ? in_rem_x : sub_x[RW-1:0];
    rem_y_nxt        = sub_y[RW] ? in_rem_y : sub_y[RW-1:0];
    q_x_nxt          = in_q_x;
    q_y_nxt          = in_q_y;
    q_x_nxt[BIT_POS] = !sub_x[RW];
    q_y_nxt[BIT_POS] = !sub_y[RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= in_tag;
    dd_r    <= in_dd;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    q_x_r   <= q_x_nxt;
    q_y_r   <= q_y_nxt;
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_dd    = dd_r;
  assign out_rem_x = rem_x_r;
  assign out_rem_y = rem_y_r;
  assign out_q_x   = q_x_r;
  assign out_q_y   = q_y_r;

endmodule

[src/line_intersection.sv]
// Line-line intersection: each accepted beat passes the front end, the magnitude and overflow stages,
// the divider row and the output register; one beat per cycle sustained, busy stays low outside reset.
// The depth is set by the divider row, one cell per quotient bit (OUT_WIDTH+1 cells).
// Synchronous active-low reset empties every stage; no result appears for beats in flight.
// Results cannot be stalled: each out_valid beat is on the ports for exactly one cycle.
// Depends on lnx_pkg, lnx_front, lnx_div_cell and line_intersection_assert.svh.
`timescale 1ns / 1ps
`include "line_intersection_assert.svh"

module line_intersection #(
  parameter int FRAC_BITS = lnx_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lnx_pkg::lnx_in_t  in_data,
  output logic              out_valid,
  output lnx_pkg::lnx_out_t out_data
);

  localparam int NX_W  = lnx_pkg::NX_W;
  localparam int DEN_W = lnx_pkg::DEN_W;
  localparam int Q_W   = lnx_pkg::Q_W;
  localparam int OW    = lnx_pkg::OUT_WIDTH;
  // divisor is den scaled by the fraction bits
  localparam int DD_W  = DEN_W + FRAC_BITS;
  // remainder only has to hold values below divisor << Q_W
  localparam int RW    = DD_W + Q_W;
  localparam int CMP_W = (NX_W > RW) ? NX_W : RW;
  localparam int LAT   = Q_W + 7;
  localparam logic [Q_W-1:0] HALF = Q_W'(1) << (OW - 1);
  localparam logic [Q_W-1:0] MAXP = HALF - Q_W'(1);

  logic accept;

  // front end output
  logic               fe_valid;
  lnx_pkg::lnx_prod_t fe_data;

  // magnitude stage
  logic [NX_W-1:0]    mag_nx_nxt, mag_ny_nxt;
  logic [DEN_W-1:0]   abs_den;
  logic               s5_valid_r;
  logic [NX_W-1:0]    s5_mag_nx_r, s5_mag_ny_r;
  logic [DD_W-1:0]    s5_mag_dd_r;
  logic               s5_hit_r, s5_neg_x_r, s5_neg_y_r;

  // overflow check stage, feeds the head of the divider row
  logic [CMP_W-1:0]   dd_top;
  logic               ovf_x_nxt, ovf_y_nxt;

  // divider row taps: index 0 is the row input, index k+1 the output of cell k
  logic               ch_valid [Q_W+1];
  lnx_pkg::lnx_tag_t  ch_tag   [Q_W+1];
  logic [DD_W-1:0]    ch_dd    [Q_W+1];
  logic [RW-1:0]      ch_rem_x [Q_W+1];
  logic [RW-1:0]      ch_rem_y [Q_W+1];
  logic [Q_W-1:0]     ch_q_x   [Q_W+1];
  logic [Q_W-1:0]     ch_q_y   [Q_W+1];

  logic               s6_valid_r;
  lnx_pkg::lnx_tag_t  s6_tag_r;
  logic [DD_W-1:0]    s6_dd_r;
  logic [RW-1:0]      s6_rem_x_r, s6_rem_y_r;

  // output stage
  logic [OW:0]        sat_x, sat_y;
  lnx_pkg::lnx_out_t  out_nxt;
  logic               out_valid_r;
  lnx_pkg::lnx_out_t  out_data_r;

  // assertion terms
  logic               tail_hit, tail_exact, tail_rem_ok;
  logic               out_hit, out_miss, miss_clean;

  // Saturate a quotient magnitude and apply the sign; bit OW of the result is the clip flag.
  function automatic logic [OW:0] sat_coord(input logic [Q_W-1:0] q, input logic neg,
                                            input logic ovf);
    logic           clip;
    logic [Q_W-1:0] v;
    if (neg) begin
      clip = ovf || (q > HALF);
      v    = clip ? HALF : q;
      return {clip, OW'(Q_W'(0) - v)};
    end else begin
      clip = ovf || (q > MAXP);
      v    = clip ? MAXP : q;
      return {clip, v[OW-1:0]};
    end
  endfunction

  // Hold busy only through reset; every other cycle can take a beat.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  lnx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .out_valid (fe_valid),
    .out_data  (fe_data)
  );

  // Take magnitudes and signs; the quotient sign is the xor of the two operand signs.
  assign mag_nx_nxt = fe_data.nx[NX_W-1] ? (~fe_data.nx + NX_W'(1)) : fe_data.nx;
  assign mag_ny_nxt = fe_data.ny[NX_W-1] ? (~fe_data.ny + NX_W'(1)) : fe_data.ny;
  assign abs_den    = fe_data.den[DEN_W-1] ? (~fe_data.den + DEN_W'(1)) : fe_data.den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= fe_valid;
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_mag_nx_r <= mag_nx_nxt;
    s5_mag_ny_r <= mag_ny_nxt;
    s5_mag_dd_r <= DD_W'(abs_den) << FRAC_BITS;
    s5_hit_r    <= (fe_data.den != '0);
    s5_neg_x_r  <= fe_data.nx[NX_W-1] ^ fe_data.den[DEN_W-1];
    s5_neg_y_r  <= fe_data.ny[NX_W-1] ^ fe_data.den[DEN_W-1];
  end

  // Flag quotients that cannot fit in Q_W bits; the row then only has to settle Q_W bits.
  // A numerator wider than the remainder is truncated only when this flag is set.
  assign dd_top    = CMP_W'(s5_mag_dd_r) << Q_W;
  assign ovf_x_nxt = CMP_W'(s5_mag_nx_r) >= dd_top;
  assign ovf_y_nxt = CMP_W'(s5_mag_ny_r) >= dd_top;

  always_ff @(posedge clk) begin
    s6_tag_r.hit   <= s5_hit_r;
    s6_tag_r.neg_x <= s5_neg_x_r;
    s6_tag_r.neg_y <= s5_neg_y_r;
    s6_tag_r.ovf_x <= ovf_x_nxt;
    s6_tag_r.ovf_y <= ovf_y_nxt;
    s6_dd_r        <= s5_mag_dd_r;
    s6_rem_x_r     <= RW'(s5_mag_nx_r);
    s6_rem_y_r     <= RW'(s5_mag_ny_r);
  end

  assign ch_valid[0] = s6_valid_r;
  assign ch_tag[0]   = s6_tag_r;
  assign ch_dd[0]    = s6_dd_r;
  assign ch_rem_x[0] = s6_rem_x_r;
  assign ch_rem_y[0] = s6_rem_y_r;
  assign ch_q_x[0]   = '0;
  assign ch_q_y[0]   = '0;

  // Divider row: cell k settles quotient bit Q_W-1-k, most significant first.
  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    lnx_div_cell #(
      .RW      (RW),
      .DD_W    (DD_W),
      .BIT_POS (Q_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[k]),
      .in_tag    (ch_tag[k]),
      .in_dd     (ch_dd[k]),
      .in_rem_x  (ch_rem_x[k]),
      .in_rem_y  (ch_rem_y[k]),
      .in_q_x    (ch_q_x[k]),
      .in_q_y    (ch_q_y[k]),
      .out_valid (ch_valid[k+1]),
      .out_tag   (ch_tag[k+1]),
      .out_dd    (ch_dd[k+1]),
      .out_rem_x (ch_rem_x[k+1]),
      .out_rem_y (ch_rem_y[k+1]),
      .out_q_x   (ch_q_x[k+1]),
      .out_q_y   (ch_q_y[k+1])
    );
  end

  // Saturate, sign and zero the beat when the lines are parallel.
  assign sat_x = sat_coord(ch_q_x[Q_W], ch_tag[Q_W].neg_x, ch_tag[Q_W].ovf_x);
  assign sat_y = sat_coord(ch_q_y[Q_W], ch_tag[Q_W].neg_y, ch_tag[Q_W].ovf_y);

  always_comb begin
    out_nxt = '0;
    if (ch_tag[Q_W].hit) begin
      out_nxt.hit     = 1'b1;
      out_nxt.cross_x = sat_x[OW-1:0];
      out_nxt.cross_y = sat_y[OW-1:0];
      out_nxt.clipped = sat_x[OW] || sat_y[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ch_valid[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tail_hit    = ch_valid[Q_W] && ch_tag[Q_W].hit;
  assign tail_exact  = tail_hit && !ch_tag[Q_W].ovf_x && !ch_tag[Q_W].ovf_y;
  assign tail_rem_ok = (ch_rem_x[Q_W] < RW'(ch_dd[Q_W])) && (ch_rem_y[Q_W] < RW'(ch_dd[Q_W]));
  assign out_hit     = out_valid && out_data.hit;
  assign out_miss    = out_valid && !out_data.hit;
  assign miss_clean  = (out_data.cross_x == '0) && (out_data.cross_y == '0) && !out_data.clipped;

  `LNX_ASSERT_NOW(a_latency, clk, rst_n, out_valid, $past(accept, LAT), "beat without accept")
  `LNX_ASSERT_NOW(a_no_hit_zero, clk, rst_n, out_miss, miss_clean, "parallel beat not zeroed")
  `LNX_ASSERT_NOW(a_rem_below, clk, rst_n, tail_exact, tail_rem_ok, "remainder not below divisor")
  `LNX_ASSERT_NEXT(a_hit_carry, clk, rst_n, tail_hit, out_hit, "hit lost in output stage")

endmodule
